// ----- rtl/sha256_message_digest_assert.svh -----
// assertion macros for the rtl file that checks itself
`ifndef SHA256_MESSAGE_DIGEST_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SHA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sha256md_pkg.sv -----
package sha256md_pkg;

    localparam int HASH_WORDS  = 8;
    localparam int SCHED_WORDS = 16;
    localparam int ROUNDS      = 64;
    localparam int BLOCK_BYTES = 64;

    localparam logic [5:0] FILL_LAST  = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'(ROUNDS - 1);
    localparam logic [2:0] WORD_LAST  = 3'(HASH_WORDS - 1);
    localparam logic [7:0] PAD_MARK   = 8'h80;

    typedef logic [HASH_WORDS-1:0][31:0]  t_vars;
    typedef logic [SCHED_WORDS-1:0][31:0] t_sched;

    typedef struct packed {
        logic       shift_byte;
        logic       round_step;
        logic [7:0] byte_val;
    } t_sched_ctl;

    localparam t_vars HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] f_bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] f_bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] f_ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] f_ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

// ----- rtl/sha256md_if.sv -----
interface sha256md_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       last_byte;

    modport source (output valid, msg_byte, has_byte, last_byte, input ready);
    modport sink   (input valid, msg_byte, has_byte, last_byte, output ready);
endinterface

interface sha256md_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- rtl/sha256_message_digest.sv -----
// sha-256 over a byte stream, at most one byte per accepted word, one round per cycle
// a plain byte is only shifted in; a byte that fills the block starts its compression
// last word: pad bytes to the end of the block, an extra block when the length spills,
// then each padded block is compressed and 8 digest words go out
// one round unit serves every round of every block; no input is taken while it works
// reset: synchronous active low, chaining words to the initial hash, counts to zero
`include "sha256_message_digest_assert.svh"

module sha256_message_digest import sha256md_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sha256md_in_if.sink           i_in,
    sha256md_out_if.source        o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_INIT,
        S_ROUND,
        S_FINAL,
        S_OUT
    } t_state;

    // control state
    t_state      r_state,     n_state;
    logic [5:0]  r_fill,      n_fill;
    logic [63:0] r_bitlen,    n_bitlen;
    logic [5:0]  r_round,     n_round;
    logic [2:0]  r_idx,       n_idx;
    logic        r_pend_last, n_pend_last;   // last came with the byte that filled a block
    logic        r_in_pad,    n_in_pad;      // block being built is padding
    logic        r_len_blk,   n_len_blk;     // this padding block carries the length
    logic        r_pad_first, n_pad_first;   // next pad byte is the marker
    t_vars       r_hash,      n_hash;

    // working variables, no reset
    t_vars       r_vars,      n_vars;

    t_sched_ctl  sched_ctl;
    logic [31:0] w_cur;
    t_vars       round_out;
    logic        in_acc;
    logic        out_acc;
    logic [5:0]  fill_after;

    sha256md_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w   (w_cur)
    );

    sha256md_round u_round (
        .i_vars (r_vars),
        .i_w    (w_cur),
        .i_k    (ROUND_K[r_round]),
        .o_vars (round_out)
    );

    // handshakes
    assign i_in.ready        = (r_state == S_IDLE);
    assign in_acc            = i_in.valid && i_in.ready;
    assign o_out.valid       = (r_state == S_OUT);
    assign out_acc           = o_out.valid && o_out.ready;
    assign o_out.digest_word = r_hash[r_idx];
    assign o_out.word_index  = r_idx;
    assign o_out.last_word   = (r_idx == WORD_LAST);

    assign fill_after = i_in.has_byte ? r_fill + 6'd1 : r_fill;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_bitlen    = r_bitlen;
        n_round     = r_round;
        n_idx       = r_idx;
        n_pend_last = r_pend_last;
        n_in_pad    = r_in_pad;
        n_len_blk   = r_len_blk;
        n_pad_first = r_pad_first;
        n_hash      = r_hash;
        n_vars      = r_vars;
        sched_ctl   = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.has_byte) begin
                        sched_ctl.shift_byte = 1'b1;
                        sched_ctl.byte_val   = i_in.msg_byte;
                        n_fill               = r_fill + 6'd1;
                        n_bitlen             = r_bitlen + 64'd8;
                    end
                    if (i_in.has_byte && r_fill == FILL_LAST) begin
                        // block full: compress first, padding follows if last
                        n_state     = S_INIT;
                        n_pend_last = i_in.last_byte;
                        n_in_pad    = 1'b0;
                    end else if (i_in.last_byte) begin
                        n_state     = S_PAD;
                        n_in_pad    = 1'b1;
                        n_pad_first = 1'b1;
                        n_len_blk   = (fill_after < LEN_POS);
                    end
                end
            end

            S_PAD: begin
                // one pad byte a cycle: marker if due, zeros, then in the length block its high byte first
                sched_ctl.shift_byte = 1'b1;
                if (r_pad_first) begin
                    sched_ctl.byte_val = PAD_MARK;
                end else if (r_len_blk && r_fill >= LEN_POS) begin
                    sched_ctl.byte_val = r_bitlen[63:56];
                    n_bitlen           = {r_bitlen[55:0], 8'h00};
                end else begin
                    sched_ctl.byte_val = 8'h00;
                end
                n_pad_first = 1'b0;
                n_fill      = r_fill + 6'd1;
                if (r_fill == FILL_LAST) begin
                    n_state = S_INIT;
                end
            end

            S_INIT: begin
                n_vars  = r_hash;
                n_round = '0;
                n_state = S_ROUND;
            end

            S_ROUND: begin
                sched_ctl.round_step = 1'b1;
                n_vars               = round_out;
                n_round              = r_round + 6'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = S_FINAL;
                end
            end

            S_FINAL: begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    n_hash[i] = r_hash[i] + r_vars[i];
                end
                if (r_in_pad && r_len_blk) begin
                    n_state = S_OUT;
                    n_idx   = '0;
                end else if (r_in_pad) begin
                    // no room for the length after the marker, length goes in the next block
                    n_state     = S_PAD;
                    n_pad_first = 1'b0;
                    n_len_blk   = 1'b1;
                end else if (r_pend_last) begin
                    n_state     = S_PAD;
                    n_in_pad    = 1'b1;
                    n_pad_first = 1'b1;
                    n_len_blk   = 1'b1;
                    n_pend_last = 1'b0;
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_OUT: begin
                if (out_acc) begin
                    if (r_idx == WORD_LAST) begin
                        // reload for the next message
                        n_state  = S_IDLE;
                        n_hash   = HASH_IV;
                        n_idx    = '0;
                        n_in_pad = 1'b0;
                        n_fill   = '0;
                        n_bitlen = '0;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_bitlen    <= '0;
            r_round     <= '0;
            r_idx       <= '0;
            r_pend_last <= 1'b0;
            r_in_pad    <= 1'b0;
            r_len_blk   <= 1'b0;
            r_pad_first <= 1'b0;
            r_hash      <= HASH_IV;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_bitlen    <= n_bitlen;
            r_round     <= n_round;
            r_idx       <= n_idx;
            r_pend_last <= n_pend_last;
            r_in_pad    <= n_in_pad;
            r_len_blk   <= n_len_blk;
            r_pad_first <= n_pad_first;
            r_hash      <= n_hash;
        end
    end

    // working variables carry no reset
    always_ff @(posedge i_clk) begin
        r_vars <= n_vars;
    end

    // checks
    `SHA_ASSERT_NOW(a_no_overlap, i_in.ready, !o_out.valid, "input ready while digest pending")
    `SHA_ASSERT_NEXT(a_digest_done, out_acc && o_out.last_word, i_in.ready, "not idle after digest")
    `SHA_ASSERT_NEXT(a_round_end, r_state == S_ROUND && r_round == ROUND_LAST, r_state == S_FINAL, "round count slip")
    `SHA_ASSERT_NOW(a_len_drained, r_state == S_OUT, r_bitlen == 64'd0 && r_fill == 6'd0, "length not consumed")

endmodule

// ----- rtl/sha256md_round.sv -----
module sha256md_round import sha256md_pkg::*; (
    input  t_vars       i_vars,
    input  logic [31:0] i_w,
    input  logic [31:0] i_k,
    output t_vars       o_vars
);

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    always_comb begin
        ch  = (i_vars[4] & i_vars[5]) ^ (~i_vars[4] & i_vars[6]);
        maj = (i_vars[0] & i_vars[1]) ^ (i_vars[0] & i_vars[2]) ^ (i_vars[1] & i_vars[2]);
        t1  = i_vars[7] + f_bsig1(i_vars[4]) + ch + i_k + i_w;
        t2  = f_bsig0(i_vars[0]) + maj;
        o_vars[7] = i_vars[6];
        o_vars[6] = i_vars[5];
        o_vars[5] = i_vars[4];
        o_vars[4] = i_vars[3] + t1;
        o_vars[3] = i_vars[2];
        o_vars[2] = i_vars[1];
        o_vars[1] = i_vars[0];
        o_vars[0] = t1 + t2;
    end

endmodule

// ----- rtl/sha256md_sched.sv -----
module sha256md_sched import sha256md_pkg::*; (
    input  logic        i_clk,
    input  t_sched_ctl  i_ctl,
    output logic [31:0] o_w
);

    // word 15 is the oldest schedule word, it doubles as the block buffer
    t_sched      r_w;
    logic [31:0] w_new;

    assign w_new = f_ssig1(r_w[1]) + r_w[6] + f_ssig0(r_w[14]) + r_w[15];
    assign o_w   = r_w[15];

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_byte) begin
            r_w <= {r_w[SCHED_WORDS-1][23:0], r_w[SCHED_WORDS-2:0], i_ctl.byte_val};
        end else if (i_ctl.round_step) begin
            r_w <= {r_w[SCHED_WORDS-2:0], w_new};
        end
    end

endmodule
